[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// condition must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  `ASSERT_AT(lbl, clk, rst_n, !(prop))
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

[src/lphi_pkg.sv]
// ----------------------------------------------------------------------------
// lphi_pkg
// types and field widths of the linear probing hash insert block
// ----------------------------------------------------------------------------
package lphi_pkg;

  localparam int ID_W     = 14;
  localparam int SLOT_W   = 7;
  localparam int STATUS_W = 2;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_READ   = 1'b1
  } lphi_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HOME   = 2'd0,
    ST_PROBED = 2'd1,
    ST_FULL   = 2'd2,
    ST_READ   = 2'd3
  } lphi_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_RD_ISSUE,
    S_RD_DATA,
    S_DONE
  } lphi_state_e;

  // controller to datapath strobes
  typedef struct packed {
    logic capture;
    logic mod_sub;
    logic probe;
    logic rd_issue;
    logic rd_data;
    logic load_out;
  } lphi_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_read;
  } lphi_sts_t;

  typedef struct packed {
    lphi_status_e          status;
    logic [SLOT_W-1:0]     slot;
    logic [ID_W-1:0]       stored_id;
    logic                  occupied;
  } lphi_res_t;

endpackage

[src/lphi_req_if.sv]
// ----------------------------------------------------------------------------
// lphi_req_if
// request channel: insert an identifier or read one slot
// ----------------------------------------------------------------------------
interface lphi_req_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [lphi_pkg::ID_W-1:0]  employee_id;
  logic [lphi_pkg::SLOT_W-1:0] slot_index;

  modport source (output valid, output kind, output employee_id, output slot_index,
                  input ready);
  modport sink   (input valid, input kind, input employee_id, input slot_index,
                  output ready);
endinterface

[src/lphi_rsp_if.sv]
// ----------------------------------------------------------------------------
// lphi_rsp_if
// response channel: one result beat per request
// ----------------------------------------------------------------------------
interface lphi_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lphi_pkg::STATUS_W-1:0] status;
  logic [lphi_pkg::SLOT_W-1:0]   slot;
  logic [lphi_pkg::ID_W-1:0]     stored_id;
  logic                          occupied;

  modport source (output valid, output status, output slot, output stored_id,
                  output occupied, input ready);
  modport sink   (input valid, input status, input slot, input stored_id,
                  input occupied, output ready);
endinterface

[src/linear_probe_hash_insert.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_insert
// open addressing hash table with linear probing, insert and slot read
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  req_i    in   kind, employee_id, slot_index
//  rsp_o    out  status, slot, stored_id, occupied
//
//  one request in flight: an insert runs hash multiply, remainder, free
//  slot search and result load, a read runs slot read and result load;
//  the result is registered and the next request beat is taken once the
//  sequencer is back in idle.
//  reset clears every occupancy bit at once, no clearing pass.
//  a stalled response holds its register; one further request runs up to
//  its result and waits there.
// ----------------------------------------------------------------------------
module linear_probe_hash_insert #(
  parameter int TABLE_SIZE = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lphi_req_if.sink     req_i,
  lphi_rsp_if.source   rsp_o
);
  import lphi_pkg::*;

  lphi_cmd_t cmd;
  lphi_sts_t sts;

  lphi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  lphi_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (req_i.kind),
    .employee_id_i (req_i.employee_id),
    .slot_index_i  (req_i.slot_index),
    .sts_o         (sts),
    .status_o      (rsp_o.status),
    .slot_o        (rsp_o.slot),
    .stored_id_o   (rsp_o.stored_id),
    .occupied_o    (rsp_o.occupied)
  );

endmodule

[src/lphi_ram.sv]
// ----------------------------------------------------------------------------
// lphi_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lphi_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/lphi_ctrl.sv]
// ----------------------------------------------------------------------------
// lphi_ctrl
// sequencer for insert and read requests, owns the response valid
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lphi_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                rsp_ready_i,
  input  lphi_pkg::lphi_sts_t sts_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  output lphi_pkg::lphi_cmd_t cmd_o
);
  import lphi_pkg::*;

  lphi_state_e state_q, state_d;
  logic        rsp_valid_q, rsp_valid_d;
  logic        out_free;

  assign out_free = !rsp_valid_q || rsp_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = sts_i.in_is_read ? S_RD_ISSUE : S_MOD;
        end
      end
      S_MOD:      state_d = S_PROBE;
      S_PROBE:    state_d = S_DONE;
      S_RD_ISSUE: state_d = S_RD_DATA;
      S_RD_DATA:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      S_MOD:      cmd_o.mod_sub  = 1'b1;
      S_PROBE:    cmd_o.probe    = 1'b1;
      S_RD_ISSUE: cmd_o.rd_issue = 1'b1;
      S_RD_DATA:  cmd_o.rd_data  = 1'b1;
      S_DONE:     cmd_o.load_out = out_free;
      default: begin
        cmd_o       = '0;
        req_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.load_out) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_o.load_out && rsp_valid_q && !rsp_ready_i)
  `ASSERT_AT(a_accept_busy, clk_i, rst_ni, (req_valid_i && req_ready_o) |=> (state_q != S_IDLE))
  `ASSERT_AT(a_one_cmd, clk_i, rst_ni, $onehot0({cmd_o.capture, cmd_o.mod_sub, cmd_o.probe, cmd_o.rd_issue, cmd_o.rd_data, cmd_o.load_out}))

endmodule

[src/lphi_dp.sv]
// ----------------------------------------------------------------------------
// lphi_dp
// hash, occupancy bits, free slot search, identifier store and result regs
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lphi_dp #(
  parameter int TABLE_SIZE = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lphi_pkg::lphi_cmd_t               cmd_i,
  input  logic                              kind_i,
  input  logic [lphi_pkg::ID_W-1:0]         employee_id_i,
  input  logic [lphi_pkg::SLOT_W-1:0]       slot_index_i,
  output lphi_pkg::lphi_sts_t               sts_o,
  output logic [lphi_pkg::STATUS_W-1:0]     status_o,
  output logic [lphi_pkg::SLOT_W-1:0]       slot_o,
  output logic [lphi_pkg::ID_W-1:0]         stored_id_o,
  output logic                              occupied_o
);
  import lphi_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
  localparam int EXT_W   = SLOT_W + IDX_W;
  // modulo by reciprocal: q' = floor(id * floor(2^SHIFT / T) / 2^SHIFT), q-1 <= q' <= q
  localparam int SHIFT   = ID_W + IDX_W;
  localparam int RECIP_W = ID_W + 1;
  localparam int PROD_W  = ID_W + RECIP_W;
  localparam int Q_W     = RECIP_W - IDX_W;
  localparam int unsigned RECIP = (32'd1 << SHIFT) / TABLE_SIZE;

  logic [ID_W-1:0]       id_q;
  logic [SLOT_W-1:0]     idx_q;
  logic [PROD_W-1:0]     prod_q;
  logic [IDX_W-1:0]      home_q, home_d;
  logic [TABLE_SIZE-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]      fill_q, fill_d;
  lphi_res_t             res_q, res_d;
  lphi_res_t             out_q;

  logic [Q_W-1:0]        quot;
  logic [ID_W-1:0]       qt;
  logic [ID_W-1:0]       rem_wide;
  logic [IDX_W:0]        rem;
  logic [TABLE_SIZE-1:0] free, upper, pick, first;
  logic [IDX_W-1:0]      pos;
  logic [EXT_W-1:0]      pos_ext;
  logic                  full;
  logic [EXT_W-1:0]      idx_ext;
  logic                  in_range;
  logic [IDX_W-1:0]      rd_addr;
  logic                  rd_occ;
  logic                  ins_we;
  logic [ID_W-1:0]       ram_rdata;

  assign sts_o.in_is_read = (kind_i == KIND_READ);

  // hash: remainder with one correction step
  assign quot     = prod_q[PROD_W-1:SHIFT];
  assign qt       = ID_W'(ID_W'(quot) * ID_W'(TABLE_SIZE));
  assign rem_wide = id_q - qt;
  assign rem      = rem_wide[IDX_W:0];

  always_comb begin
    home_d = home_q;
    if (cmd_i.mod_sub) begin
      if (rem >= (IDX_W + 1)'(TABLE_SIZE)) begin
        home_d = IDX_W'(rem - (IDX_W + 1)'(TABLE_SIZE));
      end else begin
        home_d = rem[IDX_W-1:0];
      end
    end
  end

  // wrapped search for the first free slot at or after home
  assign free  = ~valid_q;
  assign upper = free & ({TABLE_SIZE{1'b1}} << home_q);
  assign pick  = (|upper) ? upper : free;
  assign first = pick & (~pick + TABLE_SIZE'(1));

  always_comb begin
    pos = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (first[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  assign pos_ext = EXT_W'(pos);
  assign full    = (fill_q == CNT_W'(TABLE_SIZE));
  assign ins_we  = cmd_i.probe && !full;

  // read side
  assign idx_ext  = EXT_W'(idx_q);
  assign in_range = idx_ext < EXT_W'(TABLE_SIZE);
  assign rd_addr  = idx_ext[IDX_W-1:0];
  assign rd_occ   = in_range && valid_q[rd_addr];

  always_comb begin
    valid_d = valid_q;
    fill_d  = fill_q;
    if (ins_we) begin
      valid_d[pos] = 1'b1;
      fill_d       = fill_q + CNT_W'(1);
    end
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.probe) begin
      if (full) begin
        res_d.status    = ST_FULL;
        res_d.slot      = '0;
        res_d.stored_id = '0;
        res_d.occupied  = 1'b0;
      end else begin
        res_d.status    = (pos == home_q) ? ST_HOME : ST_PROBED;
        res_d.slot      = pos_ext[SLOT_W-1:0];
        res_d.stored_id = id_q;
        res_d.occupied  = 1'b1;
      end
    end else if (cmd_i.rd_data) begin
      res_d.status    = ST_READ;
      res_d.slot      = idx_q;
      res_d.stored_id = rd_occ ? ram_rdata : '0;
      res_d.occupied  = rd_occ;
    end
  end

  lphi_ram #(
    .WIDTH (ID_W),
    .DEPTH (TABLE_SIZE)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (ins_we),
    .waddr_i (pos),
    .wdata_i (id_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= '0;
    end else begin
      valid_q <= valid_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      id_q   <= employee_id_i;
      idx_q  <= slot_index_i;
      prod_q <= PROD_W'(employee_id_i) * PROD_W'(RECIP);
    end
    home_q <= home_d;
    res_q  <= res_d;
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign status_o    = out_q.status;
  assign slot_o      = out_q.slot;
  assign stored_id_o = out_q.stored_id;
  assign occupied_o  = out_q.occupied;

  `ASSERT_AT(a_fill_count, clk_i, rst_ni, fill_q == CNT_W'($countones(valid_q)))
  `ASSERT_AT(a_probe_free, clk_i, rst_ni, ins_we |-> !valid_q[pos])
  `ASSERT_AT(a_home_range, clk_i, rst_ni, cmd_i.mod_sub |=> (EXT_W'(home_q) < EXT_W'(TABLE_SIZE)))

endmodule
